// ===== hw/rtl/mvbt_pkg.sv =====
// Shared types, constants and codes for the multitouch virtual button tracker.
package mvbt_pkg;

  localparam int unsigned FingerSlots = 8;
  localparam int unsigned SlotIdxW    = (FingerSlots > 1) ? $clog2(FingerSlots) : 1;
  localparam int unsigned ButtonCount = 6;
  localparam int unsigned IdBits      = 32;
  localparam int unsigned DimW        = 12;   // window size and pixel coordinates
  localparam int unsigned EdgeW       = 14;   // rectangle edges and pad top
  localparam int unsigned FracW       = 16;
  localparam int unsigned BtnW        = 3;
  localparam int unsigned CfgIdxW     = 2;

  localparam logic [BtnW-1:0] NoButton = 3'd7;

  // floor(x/7) = (x*4682)>>15 and floor(x/9) = (x*3641)>>15, exact for x < 4096
  localparam logic [12:0] Div7Mul   = 13'd4682;
  localparam logic [11:0] Div9Mul   = 12'd3641;
  localparam int unsigned DivShift  = 15;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FUNC_DOWN   = 2'd0,
    FUNC_MOTION = 2'd1,
    FUNC_UP     = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAY_CELL,
    ST_LAY_SIZE,
    ST_LAY_RECT,
    ST_EV_SCALE,
    ST_EV_UPDATE,
    ST_EV_RESULT
  } state_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [IdBits-1:0] finger_id;
    logic [FracW-1:0]  touch_x_frac;
    logic [FracW-1:0]  touch_y_frac;
  } evt_t;

  typedef struct packed {
    logic [ButtonCount-1:0] key_mask;
    logic                   handled;
  } res_t;

  typedef struct packed {
    logic ev_load;
    logic lay_cell;
    logic lay_size;
    logic lay_rect;
    logic ev_scale;
    logic ev_update;
    logic ev_result;
  } cmd_t;

  typedef struct packed {
    logic [EdgeW-1:0] x0;
    logic [EdgeW-1:0] x1;
    logic [EdgeW-1:0] y0;
    logic [EdgeW-1:0] y1;
  } rect_t;

endpackage

// ===== hw/rtl/mvbt_ctrl.sv =====
// Sequencer for layout derivation and event processing.
module mvbt_ctrl
  import mvbt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic cfg_we_i,
  output logic busy_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cfg_we_i) begin
          state_d = ST_LAY_CELL;
        end else if (start_i) begin
          state_d = ST_EV_SCALE;
        end
      end
      ST_LAY_CELL:  state_d = ST_LAY_SIZE;
      ST_LAY_SIZE:  state_d = ST_LAY_RECT;
      ST_LAY_RECT:  state_d = ST_IDLE;
      ST_EV_SCALE:  state_d = ST_EV_UPDATE;
      ST_EV_UPDATE: state_d = ST_EV_RESULT;
      ST_EV_RESULT: state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o        = cfg_we_i;
        cmd_o.ev_load = start_i & ~cfg_we_i;
      end
      ST_LAY_CELL:  cmd_o.lay_cell  = 1'b1;
      ST_LAY_SIZE:  cmd_o.lay_size  = 1'b1;
      ST_LAY_RECT:  cmd_o.lay_rect  = 1'b1;
      ST_EV_SCALE:  cmd_o.ev_scale  = 1'b1;
      ST_EV_UPDATE: cmd_o.ev_update = 1'b1;
      ST_EV_RESULT: cmd_o.ev_result = 1'b1;
      default:      busy_o = 1'b1;
    endcase
  end

endmodule

// ===== hw/rtl/mvbt_dp.sv =====
// Datapath: window registers, button layout, finger slot table and hit test.
module mvbt_dp
  import mvbt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DimW-1:0]    cfg_wdata_i,
  input  evt_t               evt_i,
  output logic               done_o,
  output res_t               res_o
);

  // window registers
  logic [DimW-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_WIDTH) begin
        width_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == CFG_HEIGHT) begin
        height_q <= cfg_wdata_i;
      end
    end
  end

  // layout
  logic [DimW-1:0]  cell_q, margin_q, side_q;
  logic [EdgeW-1:0] pad_top_q;
  rect_t            rect_q [ButtonCount];

  logic [DimW-1:0]  min_dim;
  logic [24:0]      prod7;
  logic [23:0]      prod9;
  logic [DimW-1:0]  cell7, cell9, cell_d;
  logic [EdgeW-1:0] c_e, m_e, s_e, pt_e, w_e, h_e, pt_d;
  rect_t            rect_d [ButtonCount];

  always_comb begin
    min_dim = (width_q < height_q) ? width_q : height_q;
    prod7   = 25'(min_dim) * 25'(Div7Mul);
    prod9   = 24'(height_q) * 24'(Div9Mul);
    cell7   = DimW'(prod7 >> DivShift);
    cell9   = DimW'(prod9 >> DivShift);
    cell_d  = (cell7 > cell9) ? cell9 : cell7;
  end

  always_comb begin
    c_e  = EdgeW'(cell_q);
    m_e  = EdgeW'(margin_q);
    s_e  = EdgeW'(side_q);
    pt_e = pad_top_q;
    w_e  = EdgeW'(width_q);
    h_e  = EdgeW'(height_q);
    pt_d = EdgeW'(height_q) - (EdgeW'(cell_q) * EdgeW'(3) + (EdgeW'(cell_q >> 2) << 1));
    // left, right, up, down, jump, menu
    rect_d[0] = '{x0: m_e,             x1: m_e + c_e,
                  y0: pt_e + c_e,      y1: pt_e + (c_e << 1)};
    rect_d[1] = '{x0: m_e + (c_e << 1), x1: m_e + (c_e << 1) + c_e,
                  y0: pt_e + c_e,      y1: pt_e + (c_e << 1)};
    rect_d[2] = '{x0: m_e + c_e,       x1: m_e + (c_e << 1),
                  y0: pt_e,            y1: pt_e + c_e};
    rect_d[3] = '{x0: m_e + c_e,       x1: m_e + (c_e << 1),
                  y0: pt_e + (c_e << 1), y1: pt_e + (c_e << 1) + c_e};
    rect_d[4] = '{x0: w_e - m_e - s_e, x1: w_e - m_e,
                  y0: h_e - m_e - s_e, y1: h_e - m_e};
    rect_d[5] = '{x0: w_e - m_e - c_e, x1: w_e - m_e,
                  y0: pt_e + m_e,      y1: pt_e + m_e + c_e};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q    <= '0;
      margin_q  <= '0;
      side_q    <= '0;
      pad_top_q <= '0;
      for (int i = 0; i < ButtonCount; i++) begin
        rect_q[i] <= '0;
      end
    end else begin
      if (cmd_i.lay_cell) begin
        cell_q <= cell_d;
      end
      if (cmd_i.lay_size) begin
        margin_q  <= cell_q >> 2;
        side_q    <= cell_q + (cell_q >> 1);
        pad_top_q <= pt_d;
      end
      if (cmd_i.lay_rect) begin
        for (int i = 0; i < ButtonCount; i++) begin
          rect_q[i] <= rect_d[i];
        end
      end
    end
  end

  // event capture and scaling
  evt_t            evt_q;
  logic [DimW-1:0] px_q, py_q;
  logic [27:0]     prod_x, prod_y;

  assign prod_x = 28'(evt_q.touch_x_frac) * 28'(width_q);
  assign prod_y = 28'(evt_q.touch_y_frac) * 28'(height_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ev_load) begin
      evt_q <= evt_i;
    end
    if (cmd_i.ev_scale) begin
      px_q <= DimW'(prod_x >> FracW);
      py_q <= DimW'(prod_y >> FracW);
    end
  end

  // hit test, first match wins
  logic [BtnW-1:0]  hit_btn;
  logic [EdgeW-1:0] px_e, py_e;

  always_comb begin
    px_e    = EdgeW'(px_q);
    py_e    = EdgeW'(py_q);
    hit_btn = NoButton;
    for (int b = ButtonCount - 1; b >= 0; b--) begin
      if (px_e >= rect_q[b].x0 && px_e < rect_q[b].x1 &&
          py_e >= rect_q[b].y0 && py_e < rect_q[b].y1) begin
        hit_btn = BtnW'(b);
      end
    end
  end

  // finger slot table
  logic              used_q   [FingerSlots];
  logic [BtnW-1:0]   button_q [FingerSlots];
  logic [IdBits-1:0] finger_q [FingerSlots];

  logic                free_found, match_found;
  logic [SlotIdxW-1:0] free_idx, match_idx;

  always_comb begin
    free_found  = 1'b0;
    match_found = 1'b0;
    free_idx    = '0;
    match_idx   = '0;
    for (int i = FingerSlots - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = SlotIdxW'(i);
      end
      if (used_q[i] && finger_q[i] == evt_q.finger_id) begin
        match_found = 1'b1;
        match_idx   = SlotIdxW'(i);
      end
    end
  end

  logic enabled, do_down, do_motion, do_up;

  always_comb begin
    enabled   = (width_q != '0) && (height_q != '0);
    do_down   = enabled && evt_q.func == FUNC_DOWN && free_found;
    do_motion = enabled && evt_q.func == FUNC_MOTION && match_found;
    do_up     = enabled && evt_q.func == FUNC_UP && match_found;
  end

  logic handled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      handled_q <= 1'b0;
      for (int i = 0; i < FingerSlots; i++) begin
        used_q[i]   <= 1'b0;
        button_q[i] <= NoButton;
      end
    end else if (cmd_i.ev_update) begin
      handled_q <= do_down | do_motion | do_up;
      if (do_down) begin
        used_q[free_idx]   <= 1'b1;
        button_q[free_idx] <= hit_btn;
      end
      if (do_motion) begin
        button_q[match_idx] <= hit_btn;
      end
      if (do_up) begin
        used_q[match_idx]   <= 1'b0;
        button_q[match_idx] <= NoButton;
      end
    end
  end

  // id store has no reset, only read for used slots
  always_ff @(posedge clk_i) begin
    if (cmd_i.ev_update && do_down) begin
      finger_q[free_idx] <= evt_q.finger_id;
    end
  end

  // held mask from the slot table
  logic [ButtonCount-1:0] held_mask;

  always_comb begin
    held_mask = '0;
    for (int i = 0; i < FingerSlots; i++) begin
      for (int b = 0; b < ButtonCount; b++) begin
        if (used_q[i] && button_q[i] == BtnW'(b)) begin
          held_mask[b] = 1'b1;
        end
      end
    end
  end

  // result word
  logic done_q;
  res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.ev_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ev_result) begin
      res_q <= '{key_mask: held_mask, handled: handled_q};
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== hw/rtl/multitouch_virtual_button_tracker_core.sv =====
// Top level of the multitouch virtual button tracker.
//
// Usage:
//  - Event channel: an event word (evt_i) is taken at a rising edge with
//    start_i high and busy_o low. busy_o also rises combinationally with
//    cfg_we_i, so an event never collides with a register write.
//  - Result channel: one result word per event on res_o, flagged by done_o
//    for a single cycle; there is no back-pressure, the receiver must take it.
//  - Config: cfg_we_i/cfg_idx_i/cfg_wdata_i write window width (index 0) or
//    height (index 1). Each write taken while idle starts a layout derivation
//    (cell, margin/side/pad top, six button rectangles); busy_o stays high.
//  - Sequencing: an accepted event word is registered, then the scale
//    multiply, the slot update with hit test and the result register run
//    in turn; done_o rises with the result register. No new event is taken
//    until that sequence is over; a new event may be accepted at the edge
//    that takes its predecessor's result.
//  - Reset clears window size, layout, slot table (not its ids), held mask;
//    with a zero window every event returns the held mask with handled = 0.
module multitouch_virtual_button_tracker_core
  import mvbt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  evt_t               evt_i,
  output logic               done_o,
  output res_t               res_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DimW-1:0]    cfg_wdata_i
);

  cmd_t cmd;

  mvbt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .cfg_we_i (cfg_we_i),
    .busy_o   (busy_o),
    .cmd_o    (cmd)
  );

  mvbt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .evt_i       (evt_i),
    .done_o      (done_o),
    .res_o       (res_o)
  );

endmodule

// ===== tb/multitouch_virtual_button_tracker_core_tb.sv =====
// Self-checking testbench for the multitouch virtual button tracker core.
module multitouch_virtual_button_tracker_core_tb;
  import mvbt_pkg::*;

  localparam int unsigned TargetEvents  = 950;
  localparam int unsigned WatchdogLimit = 2000;  // cycles with no handshake at all
  localparam int unsigned IdPoolSize    = 10;

  // codes the block must tolerate but the package does not name
  localparam logic [1:0]         FUNC_RESERVED  = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi  = 2'd3;

  // button order of the hit test; bit n of key_mask is button n
  typedef enum int {
    BTN_LEFT  = 0,
    BTN_RIGHT = 1,
    BTN_UP    = 2,
    BTN_DOWN  = 3,
    BTN_JUMP  = 4,
    BTN_MENU  = 5
  } button_e;

  // Tracks window layout and the finger table, predicts the key mask word
  // for every accepted event and checks the block's result words in order.
  class key_mask_scoreboard;
    int                     win_w, win_h;
    int                     cell_sz, margin, pad_top;
    bit                     slot_used [FingerSlots];
    logic [IdBits-1:0]      slot_id   [FingerSlots];
    logic [BtnW-1:0]        slot_btn  [FingerSlots];
    logic [ButtonCount-1:0] held;
    res_t                   pending[$];
    int                     err_cnt;

    function new();
      win_w = 0; win_h = 0;
      cell_sz = 0; margin = 0; pad_top = 0;
      held = '0;
      err_cnt = 0;
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_id[i]   = '0;
        slot_btn[i]  = NoButton;
      end
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      err_cnt++;
    endtask

    // register write; layout is rederived from both dimensions
    function void write_window(logic [CfgIdxW-1:0] idx, logic [DimW-1:0] d);
      int c;
      if (idx == CFG_WIDTH) win_w = d;
      else if (idx == CFG_HEIGHT) win_h = d;
      else return;
      c = ((win_w < win_h) ? win_w : win_h) / 7;
      if (c > win_h / 9) c = win_h / 9;
      cell_sz = c;
      margin  = c / 4;
      pad_top = win_h - (3 * c + 2 * margin);
    endfunction

    // half-open square [x0,x0+sz) x [y0,y0+sz) of one button
    function void rect_of(int btn, output int x0, output int y0, output int sz);
      int s;
      s = cell_sz + cell_sz / 2;
      sz = cell_sz;
      case (btn)
        BTN_LEFT:  begin x0 = margin;               y0 = pad_top + cell_sz;     end
        BTN_RIGHT: begin x0 = margin + 2 * cell_sz; y0 = pad_top + cell_sz;     end
        BTN_UP:    begin x0 = margin + cell_sz;     y0 = pad_top;               end
        BTN_DOWN:  begin x0 = margin + cell_sz;     y0 = pad_top + 2 * cell_sz; end
        BTN_JUMP:  begin
          x0 = win_w - margin - s;
          y0 = win_h - margin - s;
          sz = s;
        end
        default:   begin x0 = win_w - margin - cell_sz; y0 = pad_top + margin; end
      endcase
    endfunction

    function logic [BtnW-1:0] hit_button(int px, int py);
      int x0, y0, sz;
      for (int b = BTN_LEFT; b <= BTN_MENU; b++) begin
        rect_of(b, x0, y0, sz);
        if (px >= x0 && px < x0 + sz && py >= y0 && py < y0 + sz) return BtnW'(b);
      end
      return NoButton;
    endfunction

    function void note_event(evt_t e);
      int   px, py, hit;
      logic handled;
      handled = 1'b0;
      hit     = -1;
      if (win_w != 0 && win_h != 0 && e.func != FUNC_RESERVED) begin
        px = (int'(e.touch_x_frac) * win_w) >> 16;
        py = (int'(e.touch_y_frac) * win_h) >> 16;
        if (e.func == FUNC_DOWN) begin
          // first free slot; a full table drops the finger
          for (int i = 0; i < FingerSlots; i++)
            if (hit < 0 && !slot_used[i]) hit = i;
          if (hit >= 0) begin
            slot_used[hit] = 1'b1;
            slot_id[hit]   = e.finger_id;
            slot_btn[hit]  = hit_button(px, py);
            handled        = 1'b1;
          end
        end else begin
          // lowest used slot holding this id
          for (int i = 0; i < FingerSlots; i++)
            if (hit < 0 && slot_used[i] && slot_id[i] == e.finger_id) hit = i;
          if (hit >= 0) begin
            handled = 1'b1;
            if (e.func == FUNC_MOTION) begin
              slot_btn[hit] = hit_button(px, py);
            end else begin
              slot_used[hit] = 1'b0;
              slot_btn[hit]  = NoButton;
            end
          end
        end
        held = '0;
        for (int i = 0; i < FingerSlots; i++)
          if (slot_used[i] && slot_btn[i] < ButtonCount) held[slot_btn[i]] = 1'b1;
      end
      pending.push_back('{key_mask: held, handled: handled});
    endfunction

    task check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        report($sformatf("result word with no event pending: mask=%h handled=%b",
                         got.key_mask, got.handled));
        return;
      end
      want = pending.pop_front();
      if (got.key_mask !== want.key_mask)
        report($sformatf("key_mask got %h want %h", got.key_mask, want.key_mask));
      if (got.handled !== want.handled)
        report($sformatf("handled got %b want %b", got.handled, want.handled));
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  evt_t               evt_i;
  logic               done_o;
  res_t               res_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [DimW-1:0]    cfg_wdata_i;

  key_mask_scoreboard sb;
  evt_t               stim_q[$];
  logic [IdBits-1:0]  id_pool[IdPoolSize];
  int                 stall_cycles;

  multitouch_virtual_button_tracker_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .evt_i       (evt_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic evt_t mk_evt(logic [1:0] fn, logic [IdBits-1:0] id,
                                  logic [FracW-1:0] fx, logic [FracW-1:0] fy);
    evt_t e;
    e.func         = fn;
    e.finger_id    = id;
    e.touch_x_frac = fx;
    e.touch_y_frac = fy;
    return e;
  endfunction

  // smallest fraction that scales back to pixel p
  function automatic logic [FracW-1:0] frac_for(int p, int dim);
    longint v;
    v = ((longint'(p) << 16) + dim - 1) / dim;
    return v[FracW-1:0];
  endfunction

  // pixel in or around a span, often right on or just past its edges
  function automatic int pick_px(int lo, int sz, int dim);
    int p;
    if (sz == 0) p = $urandom_range(0, dim - 1);
    else begin
      case ($urandom_range(0, 7))
        0:       p = lo - 1;
        1:       p = lo;
        2:       p = lo + sz - 1;
        3:       p = lo + sz;
        default: p = lo + $urandom_range(0, sz - 1);
      endcase
    end
    if (p < 0) p = 0;
    if (p > dim - 1) p = dim - 1;
    return p;
  endfunction

  // event aimed at one button of the current layout
  function automatic evt_t mk_aimed(logic [1:0] fn, logic [IdBits-1:0] id, int btn);
    evt_t e;
    int   x0, y0, sz;
    e = mk_evt(fn, id, FracW'($urandom), FracW'($urandom));
    if (sb.win_w != 0 && sb.win_h != 0) begin
      sb.rect_of(btn, x0, y0, sz);
      e.touch_x_frac = frac_for(pick_px(x0, sz, sb.win_w), sb.win_w);
      e.touch_y_frac = frac_for(pick_px(y0, sz, sb.win_h), sb.win_h);
    end
    return e;
  endfunction

  function automatic evt_t rand_event(int down_pct);
    int                r;
    logic [1:0]        fn;
    logic [IdBits-1:0] id;
    r = $urandom_range(0, 99);
    if (r < down_pct)  fn = FUNC_DOWN;
    else if (r < 97)   fn = $urandom_range(0, 1) ? FUNC_MOTION : FUNC_UP;
    else               fn = FUNC_RESERVED;
    // mostly known fingers so motion and up find their slot
    id = ($urandom_range(0, 6) == 0) ? IdBits'($urandom)
                                     : id_pool[$urandom_range(0, IdPoolSize - 1)];
    if ($urandom_range(0, 9) < 7) return mk_aimed(fn, id, $urandom_range(BTN_LEFT, BTN_MENU));
    return mk_evt(fn, id, FracW'($urandom), FracW'($urandom));
  endfunction

  function automatic logic [DimW-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return '0;
    if (r < 12) return '1;
    if (r < 20) return DimW'($urandom_range(1, 16));
    return DimW'($urandom_range(17, 4095));
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // hold the event word until the block takes it; start_i is left high
  task automatic send_event(evt_t e);
    start_i <= 1'b1;
    evt_i   <= e;
    do @(posedge clk_i); while (busy_o);
  endtask

  // at least one edge, then until no result word is owed and the block is idle
  task automatic wait_quiet();
    do @(posedge clk_i); while (sb.pending.size() != 0 || busy_o);
  endtask

  // only called while idle; returns once the layout pass has finished
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DimW-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    do @(posedge clk_i); while (busy_o);
  endtask

  // play out the queued events in bursts; every burst ends with start_i low,
  // now and then until all results are in
  task automatic feed_events();
    int burst;
    while (stim_q.size() > 0) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      while (burst > 0 && stim_q.size() > 0) begin
        send_event(stim_q.pop_front());
        burst--;
      end
      start_i <= 1'b0;
      if ($urandom_range(0, 24) == 0) wait_quiet();
      else repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // ---------------------------------------------------------------------
  // Monitor: results first, then config and event handshakes; the watchdog
  // restarts on any handshake
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(res_o);
      if (cfg_we_i) sb.write_window(cfg_idx_i, cfg_wdata_i);
      if (start_i && !busy_o) sb.note_event(evt_i);
      if (done_o || cfg_we_i || (start_i && !busy_o)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WatchdogLimit) begin
        $display("multitouch_virtual_button_tracker_core verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int unsigned counted;
    int          n, down_pct, which;
    evt_t        e;

    sb           = new();
    stall_cycles = 0;
    counted      = 0;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    evt_i        = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_WIDTH;
    cfg_wdata_i  = '0;
    id_pool[0]   = '0;
    id_pool[1]   = '1;
    for (int i = 2; i < IdPoolSize; i++) id_pool[i] = IdBits'($urandom);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // window still zero out of reset: events are ignored
    stim_q.push_back(mk_evt(FUNC_DOWN, '0, '0, '0));
    stim_q.push_back(mk_evt(FUNC_RESERVED, '1, '1, '1));
    feed_events();
    wait_quiet();

    // largest window: every button, duplicate id, full table, unknown finger
    write_reg(CFG_WIDTH, '1);
    write_reg(CFG_HEIGHT, '1);
    stim_q.push_back(mk_aimed(FUNC_DOWN, '0, BTN_LEFT));
    stim_q.push_back(mk_aimed(FUNC_DOWN, '1, BTN_JUMP));
    stim_q.push_back(mk_aimed(FUNC_DOWN, '0, BTN_MENU));
    stim_q.push_back(mk_aimed(FUNC_MOTION, '0, BTN_RIGHT));
    stim_q.push_back(mk_aimed(FUNC_MOTION, 32'h5A5A_A5A5, BTN_UP));
    stim_q.push_back(mk_evt(FUNC_DOWN, 32'd1, '1, '1));
    stim_q.push_back(mk_evt(FUNC_DOWN, 32'd2, '0, '0));
    stim_q.push_back(mk_aimed(FUNC_DOWN, 32'd3, BTN_UP));
    stim_q.push_back(mk_aimed(FUNC_DOWN, 32'd4, BTN_DOWN));
    stim_q.push_back(mk_aimed(FUNC_DOWN, 32'd5, BTN_LEFT));
    stim_q.push_back(mk_aimed(FUNC_DOWN, 32'd6, BTN_RIGHT));  // table full, dropped
    stim_q.push_back(mk_aimed(FUNC_RESERVED, 32'd1, BTN_JUMP));
    stim_q.push_back(mk_evt(FUNC_UP, '1, '0, '0));
    stim_q.push_back(mk_evt(FUNC_UP, '0, '0, '0));
    stim_q.push_back(mk_evt(FUNC_UP, '0, '0, '0));
    stim_q.push_back(mk_evt(FUNC_UP, '0, '0, '0));           // no longer held
    feed_events();
    wait_quiet();

    // out of range index is dropped; zero width freezes the table
    write_reg(CfgIdxSpareLo, '1);
    write_reg(CFG_WIDTH, '0);
    stim_q.push_back(mk_evt(FUNC_MOTION, 32'd1, '1, '0));
    stim_q.push_back(mk_evt(FUNC_UP, 32'd2, '0, '1));
    feed_events();
    wait_quiet();

    // window too small for any button: cell size is zero
    write_reg(CfgIdxSpareHi, '0);
    write_reg(CFG_WIDTH, 12'd6);
    write_reg(CFG_HEIGHT, 12'd8);
    stim_q.push_back(mk_evt(FUNC_DOWN, 32'd7, FracW'($urandom), FracW'($urandom)));
    stim_q.push_back(mk_evt(FUNC_MOTION, 32'd7, '1, '1));
    feed_events();

    // random phases, each under a new window size
    while (counted < TargetEvents) begin
      wait_quiet();
      if ($urandom_range(0, 4) == 0)
        write_reg($urandom_range(0, 1) ? CfgIdxSpareHi : CfgIdxSpareLo, DimW'($urandom));
      which = $urandom_range(0, 2);
      if (which != 1) write_reg(CFG_WIDTH, pick_dim());
      if (which != 0) write_reg(CFG_HEIGHT, pick_dim());
      down_pct = $urandom_range(20, 60);
      n        = $urandom_range(25, 70);
      repeat (n) begin
        e = rand_event(down_pct);
        stim_q.push_back(e);
        counted++;
      end
      feed_events();
    end

    // drain, then wait on for any stray result word
    wait_quiet();
    repeat (12) @(posedge clk_i);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d result words never arrived", sb.pending.size()));
    if (sb.err_cnt == 0) begin
      $display("multitouch_virtual_button_tracker_core verification clean");
    end else begin
      $display("multitouch_virtual_button_tracker_core verification failed");
    end
    $finish;
  end

endmodule

// ===== multitouch_virtual_button_tracker_core.f =====
hw/rtl/mvbt_pkg.sv
hw/rtl/mvbt_ctrl.sv
hw/rtl/mvbt_dp.sv
hw/rtl/multitouch_virtual_button_tracker_core.sv
tb/multitouch_virtual_button_tracker_core_tb.sv
